FILE: src/retxy_pkg.sv
// shared types, constants, microcode program and helper functions for the region et block
`default_nettype none

package retxy_pkg;

  localparam int unsigned NUM_BINS        = 18;
  localparam int unsigned NUM_ANGLES      = 5;
  localparam int unsigned COMPONENT_SHIFT = 25;

  localparam int unsigned BIN_W   = 16;
  localparam int unsigned ET_W    = 10;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned ANG_W   = 3;
  localparam int unsigned PROJ_W  = 19;
  localparam int unsigned TRIG_W  = 32;
  localparam int unsigned PROD_W  = 50;
  localparam int unsigned SUM_W   = 52;
  localparam int unsigned TOTAL_W = 21;
  localparam int unsigned STEP_W  = 3;

  // 2^30 scaled cos and sin of k * 20 degrees
  localparam logic signed [TRIG_W-1:0] COS_TAB [NUM_ANGLES] = '{
    32'sd1073741824, 32'sd1008987268, 32'sd822533957, 32'sd536870912, 32'sd186453311
  };
  localparam logic signed [TRIG_W-1:0] SIN_TAB [NUM_ANGLES] = '{
    32'sd0, 32'sd367241332, 32'sd690187940, 32'sd929887696, 32'sd1057429273
  };

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = 3'd0;
  localparam step_t STEP_ACC  = 3'd1;
  localparam step_t STEP_FOLD = 3'd2;
  localparam step_t STEP_MUL  = 3'd3;
  localparam step_t STEP_ADD  = 3'd4;
  localparam step_t STEP_OUT  = 3'd5;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ACC,
    OP_FOLD,
    OP_MUL,
    OP_ADD,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    JC_ALWAYS,
    JC_NO_BEAT,
    JC_NOT_LAST,
    JC_CNT_NE,
    JC_OUT_BUSY
  } jc_e;

  // one control word: datapath op, jump condition, loop limit, targets, count enable
  typedef struct packed {
    op_e              op;
    jc_e              jc;
    logic [CNT_W-1:0] lim;
    step_t            tgt;
    step_t            alt;
    logic             inc;
  } uword_t;

  typedef struct packed {
    logic [ANG_W-1:0] k;
    logic             c_neg;
    logic             s_neg;
  } fold_t;

  // control store: jump to tgt when the condition holds, else to alt
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w = '{op: OP_IDLE, jc: JC_ALWAYS, lim: '0, tgt: STEP_IDLE, alt: STEP_IDLE, inc: 1'b0};
    case (pc)
      STEP_IDLE: w = '{op: OP_IDLE, jc: JC_NO_BEAT,  lim: 5'd0,
                       tgt: STEP_IDLE, alt: STEP_ACC,  inc: 1'b0};
      STEP_ACC:  w = '{op: OP_ACC,  jc: JC_NOT_LAST, lim: 5'd0,
                       tgt: STEP_IDLE, alt: STEP_FOLD, inc: 1'b0};
      STEP_FOLD: w = '{op: OP_FOLD, jc: JC_CNT_NE,   lim: 5'(NUM_BINS - 1),
                       tgt: STEP_FOLD, alt: STEP_MUL,  inc: 1'b1};
      STEP_MUL:  w = '{op: OP_MUL,  jc: JC_ALWAYS,   lim: 5'd0,
                       tgt: STEP_ADD,  alt: STEP_ADD,  inc: 1'b0};
      STEP_ADD:  w = '{op: OP_ADD,  jc: JC_CNT_NE,   lim: 5'(NUM_ANGLES - 1),
                       tgt: STEP_MUL,  alt: STEP_OUT,  inc: 1'b1};
      STEP_OUT:  w = '{op: OP_OUT,  jc: JC_OUT_BUSY, lim: 5'd0,
                       tgt: STEP_OUT,  alt: STEP_IDLE, inc: 1'b0};
      default:   w = '{op: OP_IDLE, jc: JC_ALWAYS,   lim: 5'd0,
                       tgt: STEP_IDLE, alt: STEP_IDLE, inc: 1'b0};
    endcase
    return w;
  endfunction

  // phi bin from crate and card: p = crate mod 9, doubled per card, bin = (22 - p) mod 18
  function automatic logic [CNT_W-1:0] bin_of(input logic [4:0] crate, input logic [2:0] card,
                                               input logic half);
    logic [4:0] p;
    logic [4:0] p2;
    logic [4:0] t;
    if (crate >= 5'd27) begin
      p = crate - 5'd27;
    end else if (crate >= 5'd18) begin
      p = crate - 5'd18;
    end else if (crate >= 5'd9) begin
      p = crate - 5'd9;
    end else begin
      p = crate;
    end
    case (card)
      3'd0, 3'd2, 3'd4: p2 = {p[3:0], 1'b0};
      3'd1, 3'd3, 3'd5: p2 = {p[3:0], 1'b1};
      3'd6:             p2 = {p[3:0], half};
      default:          p2 = p;
    endcase
    t = 5'd22 - p2;
    return (t >= 5'd18) ? (t - 5'd18) : t;
  endfunction

  // which angle a bin folds into and with which signs
  function automatic fold_t fold_map(input logic [CNT_W-1:0] i);
    fold_t f;
    if (i < 5'd5) begin
      f = '{k: i[ANG_W-1:0], c_neg: 1'b0, s_neg: 1'b0};
    end else if (i < 5'd9) begin
      f = '{k: ANG_W'(5'd9 - i), c_neg: 1'b1, s_neg: 1'b0};
    end else if (i < 5'd14) begin
      f = '{k: ANG_W'(i - 5'd9), c_neg: 1'b1, s_neg: 1'b1};
    end else begin
      f = '{k: ANG_W'(5'd18 - i), c_neg: 1'b0, s_neg: 1'b1};
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: src/retxy_if.sv
// valid/ready channel interfaces for region beats and result beats
`default_nettype none

interface retxy_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] crate_index;
  logic [2:0] card_index;
  logic       region_half;
  logic [9:0] region_et;
  logic       region_valid;
  logic       event_last;

  modport source (output valid, crate_index, card_index, region_half, region_et,
                  region_valid, event_last, input ready);
  modport sink (input valid, crate_index, card_index, region_half, region_et,
                region_valid, event_last, output ready);
endinterface

interface retxy_out_if;
  logic               valid;
  logic               ready;
  logic [12:0]        total_et;
  logic signed [23:0] x_component;
  logic signed [23:0] y_component;

  modport source (output valid, total_et, x_component, y_component, input ready);
  modport sink (input valid, total_et, x_component, y_component, output ready);
endinterface

`default_nettype wire

FILE: src/region_et_sum_and_xy_projection.sv
// region et accumulator with phi-bin fold and x/y projection, run by a microcoded sequencer
//
// usage
//   in_i  : one region beat per handshake (crate, card, region half, 10-bit et, region
//           valid flag, event last flag); region_valid low makes a beat that skips the bins
//   out_o : one result beat per event, sent after the beat with event_last set:
//           13-bit total et (bit 12 flags overflow) and signed 24-bit x and y
//   a beat that does not close the event is accepted at the idle step, then gets one
//   read-add-saturate-write of the 18-entry bin file through its single read port
//   a closing beat then runs 18 fold steps (one bin per cycle through the same port),
//   5 multiply/accumulate pairs on the shared cos/sin multiplier pair and one output
//   step that loads the output register and returns the sequencer to idle
//   in_i.ready is high only while the sequencer sits at its idle step
//   if out_o stalls, the previous result stays in the output register while new
//   region beats are still taken; a second result waits at the output step
//   reset (rst_ni low, asynchronous) clears the bins, the partial sums, the step
//   pointer and the output valid; bins clear again after every result
`default_nettype none

module region_et_sum_and_xy_projection (
  input  logic           clk_i,
  input  logic           rst_ni,
  retxy_in_if.sink       in_i,
  retxy_out_if.source    out_o
);

  localparam int unsigned BW = retxy_pkg::BIN_W;
  localparam int unsigned CW = retxy_pkg::CNT_W;
  localparam int unsigned PJ = retxy_pkg::PROJ_W;
  localparam int unsigned PW = retxy_pkg::PROD_W;
  localparam int unsigned SW = retxy_pkg::SUM_W;
  localparam int unsigned TW = retxy_pkg::TOTAL_W;

  // sequencer
  retxy_pkg::step_t  pc_q, pc_d;
  retxy_pkg::uword_t uw;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              taken;
  logic              in_beat;
  logic              out_busy;
  logic              out_load;

  // latched region beat
  logic [4:0]                      crate_q;
  logic [2:0]                      card_q;
  logic                            half_q;
  logic [retxy_pkg::ET_W-1:0]      et_q;
  logic                            valid_q;
  logic                            last_q;

  // bin file and fold sums
  logic [BW-1:0]        bins_q [retxy_pkg::NUM_BINS];
  logic signed [PJ-1:0] cs_q [retxy_pkg::NUM_ANGLES];
  logic signed [PJ-1:0] ss_q [retxy_pkg::NUM_ANGLES];
  logic [TW-1:0]        total_q;
  logic signed [PW-1:0] prod_x_q, prod_y_q;
  logic signed [SW-1:0] sum_x_q, sum_y_q;

  // output register
  logic               out_valid_q;
  logic [12:0]        total_et_q;
  logic signed [23:0] x_q, y_q;

  // datapath nets
  logic [CW-1:0]             bin_sel;
  logic [CW-1:0]             rd_idx;
  logic [BW-1:0]             rd_bin;
  logic [BW:0]               acc_sum;
  logic [BW-1:0]             acc_sat;
  retxy_pkg::fold_t          fm;
  logic signed [PJ-1:0]      bin_ext;
  logic [retxy_pkg::ANG_W-1:0] kx;

  assign uw       = retxy_pkg::ucode(pc_q);
  assign in_i.ready = (uw.op == retxy_pkg::OP_IDLE);
  assign in_beat  = in_i.valid && in_i.ready;
  assign out_busy = out_valid_q && !out_o.ready;
  // output step with a free output register
  assign out_load = (uw.op == retxy_pkg::OP_OUT) && !out_busy;

  // jump condition for the current control word
  always_comb begin
    case (uw.jc)
      retxy_pkg::JC_ALWAYS:   taken = 1'b1;
      retxy_pkg::JC_NO_BEAT:  taken = !in_i.valid;
      retxy_pkg::JC_NOT_LAST: taken = !last_q;
      retxy_pkg::JC_CNT_NE:   taken = (cnt_q != uw.lim);
      retxy_pkg::JC_OUT_BUSY: taken = out_busy;
      default:                taken = 1'b1;
    endcase
  end

  // loop counter steps while a loop jumps back, clears on fall-through
  always_comb begin
    pc_d  = taken ? uw.tgt : uw.alt;
    cnt_d = taken ? (uw.inc ? cnt_q + CW'(1) : cnt_q) : '0;
  end

  // single read port on the bin file: update address or fold sweep
  assign bin_sel = retxy_pkg::bin_of(crate_q, card_q, half_q);
  assign rd_idx  = (uw.op == retxy_pkg::OP_FOLD) ? cnt_q : bin_sel;
  assign rd_bin  = bins_q[rd_idx];
  assign acc_sum = {1'b0, rd_bin} + (BW + 1)'(et_q);
  assign acc_sat = acc_sum[BW] ? {BW{1'b1}} : acc_sum[BW-1:0];

  assign fm      = retxy_pkg::fold_map(cnt_q);
  assign bin_ext = $signed(PJ'(rd_bin));
  assign kx      = cnt_q[retxy_pkg::ANG_W-1:0];

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= retxy_pkg::STEP_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      for (int i = 0; i < retxy_pkg::NUM_BINS; i++) begin
        bins_q[i] <= '0;
      end
      for (int i = 0; i < retxy_pkg::NUM_ANGLES; i++) begin
        cs_q[i] <= '0;
        ss_q[i] <= '0;
      end
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
      // a new result may replace the one taken at this same edge
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (uw.op)
        retxy_pkg::OP_ACC: begin
          if (valid_q) begin
            bins_q[bin_sel] <= acc_sat;
          end
        end
        retxy_pkg::OP_FOLD: begin
          total_q  <= total_q + TW'(rd_bin);
          cs_q[fm.k] <= fm.c_neg ? (cs_q[fm.k] - bin_ext) : (cs_q[fm.k] + bin_ext);
          ss_q[fm.k] <= fm.s_neg ? (ss_q[fm.k] - bin_ext) : (ss_q[fm.k] + bin_ext);
        end
        retxy_pkg::OP_ADD: begin
          sum_x_q <= sum_x_q + SW'(prod_x_q);
          sum_y_q <= sum_y_q + SW'(prod_y_q);
        end
        retxy_pkg::OP_OUT: begin
          if (!out_busy) begin
            // result goes out, event state starts over
            total_q     <= '0;
            sum_x_q     <= '0;
            sum_y_q     <= '0;
            for (int i = 0; i < retxy_pkg::NUM_BINS; i++) begin
              bins_q[i] <= '0;
            end
            for (int i = 0; i < retxy_pkg::NUM_ANGLES; i++) begin
              cs_q[i] <= '0;
              ss_q[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers: input latch, products, output
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      crate_q <= in_i.crate_index;
      card_q  <= in_i.card_index;
      half_q  <= in_i.region_half;
      et_q    <= in_i.region_et;
      valid_q <= in_i.region_valid;
      last_q  <= in_i.event_last;
    end
    if (uw.op == retxy_pkg::OP_MUL) begin
      prod_x_q <= PW'(cs_q[kx]) * PW'(retxy_pkg::COS_TAB[kx]);
      prod_y_q <= PW'(ss_q[kx]) * PW'(retxy_pkg::SIN_TAB[kx]);
    end
    if (out_load) begin
      total_et_q <= {(|total_q[TW-1:12]), total_q[11:0]};
      x_q        <= 24'(sum_x_q >>> retxy_pkg::COMPONENT_SHIFT);
      y_q        <= 24'(sum_y_q >>> retxy_pkg::COMPONENT_SHIFT);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.total_et    = total_et_q;
  assign out_o.x_component = x_q;
  assign out_o.y_component = y_q;

  // an accepted beat is always followed by its bin update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (pc_q == retxy_pkg::STEP_ACC))
    else $error("accepted beat not followed by bin update");

  // fold sweep stays inside the bin file
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == retxy_pkg::STEP_FOLD) |-> (cnt_q < CW'(retxy_pkg::NUM_BINS)))
    else $error("fold counter beyond last bin");

  // multiply loop stays inside the angle tables
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pc_q == retxy_pkg::STEP_MUL) || (pc_q == retxy_pkg::STEP_ADD))
      |-> (cnt_q < CW'(retxy_pkg::NUM_ANGLES)))
    else $error("angle counter out of range");

  // a result only appears from the output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(pc_q) == retxy_pkg::STEP_OUT))
    else $error("result raised outside the output step");

  // counter is clear whenever the sequencer idles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (cnt_q == '0))
    else $error("loop counter not clear at idle");

endmodule

`default_nettype wire
